// ----- sv/wto_pkg.sv -----
// types and constants shared by the wavetable oscillator
package wto_pkg;

  typedef logic [23:0]        freq_t;
  typedef logic [31:0]        phase_t;
  typedef logic signed [15:0] sample_t;
  typedef logic [8:0]         tindex_t;
  typedef logic [1:0]         cfg_index_t;
  typedef logic [31:0]        cfg_data_t;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  localparam cfg_index_t REG_FREQ_MODE   = 2'd0;
  localparam cfg_index_t REG_FIXED_FREQ  = 2'd1;
  localparam cfg_index_t REG_HZ_TO_PHASE = 2'd2;

  localparam freq_t  FIXED_FREQ_RESET  = 24'd112640;
  localparam phase_t HZ_TO_PHASE_RESET = 32'd22906492;

endpackage

// ----- sv/wavetable_oscillator_interp_core.sv -----
// wavetable oscillator with phase accumulator and linear interpolation
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_stall    cmd, freq_hz, table_index, table_value
//   out      output     out_valid / out_stall  sample
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one word is taken every cycle unless the pipeline holds; a generate word runs through stages 0 to 4 to the output
// the stages do the increment multiply, position scaling, table read and interpolation multiply
// the whole pipeline holds while a sample waits at the output with out_stall high
// reset clears the phase, the pipeline and the registers; table contents are left as they are
// cfg_ready is always high; writes to an unknown index are dropped
module wavetable_oscillator_interp_core #(
  parameter int TABLE_SIZE = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  wto_pkg::freq_t      freq_hz,
  input  wto_pkg::tindex_t    table_index,
  input  wto_pkg::sample_t    table_value,
  output logic                out_valid,
  input  logic                out_stall,
  output wto_pkg::sample_t    sample,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  wto_pkg::cfg_index_t cfg_index,
  input  wto_pkg::cfg_data_t  cfg_data
);
  import wto_pkg::*;

  localparam int ADDR_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int POS_W  = 32 + ADDR_W;
  localparam logic [POS_W:0]    POS_MOD  = (POS_W + 1)'(TABLE_SIZE) << 32;
  localparam logic [POS_W-1:0]  SIZE_POS = POS_W'(TABLE_SIZE);
  localparam logic [ADDR_W-1:0] LAST     = ADDR_W'(TABLE_SIZE - 1);
  localparam logic [16:0]       SIZE_IDX = 17'(TABLE_SIZE);

  // configuration
  logic   freq_mode;
  freq_t  fixed_freq;
  phase_t hz_to_phase;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_mode   <= 1'b0;
      fixed_freq  <= FIXED_FREQ_RESET;
      hz_to_phase <= HZ_TO_PHASE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FREQ_MODE:   freq_mode   <= cfg_data[0];
        REG_FIXED_FREQ:  fixed_freq  <= cfg_data[23:0];
        REG_HZ_TO_PHASE: hz_to_phase <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a sample is held at the output
  logic adv;
  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  // stage 0: input word
  logic    s0_valid, s0_cmd;
  freq_t   s0_freq;
  tindex_t s0_idx;
  sample_t s0_val;

  // stage 1: phase increment
  logic    s1_valid, s1_cmd;
  phase_t  s1_inc;
  tindex_t s1_idx;
  sample_t s1_val;

  // stage 2: increment scaled to table positions
  logic             s2_valid, s2_cmd;
  logic [POS_W-1:0] s2_step;
  tindex_t          s2_idx;
  sample_t          s2_val;

  // position accumulator, phase times table size
  logic [POS_W-1:0] pos;
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] pos_next;

  // stage 3: table entries read
  logic        s3_valid;
  sample_t     s3_v1, s3_v2;
  logic [15:0] s3_frac;

  // stage 4: interpolation product
  logic               s4_valid;
  sample_t            s4_v1;
  logic signed [33:0] s4_prod;

  sample_t mem [TABLE_SIZE];

  freq_t            f_sel;
  logic [55:0]      inc_full;
  logic [ADDR_W-1:0] rd_a1, rd_a2, wr_addr;
  logic             wr_en;
  logic signed [16:0] diff;
  logic signed [18:0] interp;
  sample_t          sample_next;

  assign f_sel    = freq_mode ? s0_freq : fixed_freq;
  assign inc_full = 56'(f_sel) * 56'(hz_to_phase);

  assign pos_sum  = {1'b0, pos} + {1'b0, s2_step};
  assign pos_next = (pos_sum >= POS_MOD) ? POS_W'(pos_sum - POS_MOD) : pos_sum[POS_W-1:0];

  assign rd_a1   = pos[POS_W-1:32];
  assign rd_a2   = (rd_a1 == LAST) ? '0 : rd_a1 + 1'b1;
  assign wr_addr = ADDR_W'(s2_idx);
  assign wr_en   = s2_valid && (s2_cmd == CMD_WRITE) && (17'(s2_idx) < SIZE_IDX);

  assign diff   = 17'(s3_v2) - 17'(s3_v1);
  assign interp = 19'(s4_v1) + 19'(s4_prod >>> 16);
  always_comb begin
    if (interp > 19'sd32767) begin
      sample_next = 16'sh7fff;
    end else if (interp < -19'sd32768) begin
      sample_next = 16'sh8000;
    end else begin
      sample_next = interp[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (adv) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && (s2_cmd == CMD_GENERATE);
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
      if (s2_valid && (s2_cmd == CMD_GENERATE)) begin
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd  <= cmd;
      s0_freq <= freq_hz;
      s0_idx  <= table_index;
      s0_val  <= table_value;

      s1_cmd <= s0_cmd;
      s1_inc <= inc_full[47:16];
      s1_idx <= s0_idx;
      s1_val <= s0_val;

      s2_cmd  <= s1_cmd;
      s2_step <= POS_W'({{ADDR_W{1'b0}}, s1_inc} * SIZE_POS);
      s2_idx  <= s1_idx;
      s2_val  <= s1_val;

      s3_frac <= pos[31:16];

      s4_v1   <= s3_v1;
      s4_prod <= 34'(diff) * $signed({18'b0, s3_frac});

      sample <= sample_next;
    end
  end

  // table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        mem[wr_addr] <= s2_val;
      end
      s3_v1 <= mem[rd_a1];
      s3_v2 <= mem[rd_a2];
    end
  end

endmodule

// ----- tb/sv/wavetable_oscillator_interp_checker.sv -----
// checker for the wavetable oscillator: predicts each sample and compares at the output
`timescale 1ns / 100ps

module wavetable_oscillator_interp_checker
  import wto_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       cmd,
  input  freq_t      freq_hz,
  input  tindex_t    table_index,
  input  sample_t    table_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  sample_t    sample,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  output int         fails,
  output int         pending,
  output int         checked
);

  localparam int TABLE_DEPTH = 512;

  logic    use_item_freq;
  freq_t   fixed_freq_reg;
  phase_t  hz_step_reg;
  phase_t  osc_phase;
  sample_t wave_mem [TABLE_DEPTH];
  sample_t expected_samples [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fails++;
  endtask

  // top 9 phase bits pick the entry, the next 16 interpolate toward its neighbour
  function automatic sample_t interp_sample(phase_t ph);
    tindex_t     lo_idx;
    tindex_t     hi_idx;
    logic [15:0] frac;
    longint      v_lo;
    longint      v_hi;
    longint      acc;
    lo_idx = ph[31:23];
    hi_idx = lo_idx + 1'b1;
    frac   = ph[22:7];
    v_lo   = wave_mem[lo_idx];
    v_hi   = wave_mem[hi_idx];
    acc    = v_lo + (((v_hi - v_lo) * longint'(frac)) >>> 16);
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return sample_t'(acc);
  endfunction

  function automatic phase_t phase_step(freq_t f);
    logic [63:0] prod;
    prod = 64'(f) * 64'(hz_step_reg);
    return prod[47:16];
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      use_item_freq  = 1'b0;
      fixed_freq_reg = FIXED_FREQ_RESET;
      hz_step_reg    = HZ_TO_PHASE_RESET;
      osc_phase      = '0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with no request waiting", sample));
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (sample !== want)
            report_mismatch($sformatf("sample got %0d expected %0d", sample, want));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FREQ_MODE:   use_item_freq  = cfg_data[0];
          REG_FIXED_FREQ:  fixed_freq_reg = cfg_data[23:0];
          REG_HZ_TO_PHASE: hz_step_reg    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (cmd == CMD_WRITE) begin
          wave_mem[table_index] = table_value;
        end else begin
          // sample first, then the phase moves on
          expected_samples.push_back(interp_sample(osc_phase));
          osc_phase = osc_phase + phase_step(use_item_freq ? freq_hz : fixed_freq_reg);
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ----- tb/sv/wavetable_oscillator_interp_core_test.sv -----
// testbench top for the wavetable oscillator: stimulus, stalls and verdict
`timescale 1ns / 100ps

module wavetable_oscillator_interp_core_test;
  import wto_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = CMD_GENERATE;
  freq_t      freq_hz = '0;
  tindex_t    table_index = '0;
  sample_t    table_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  sample_t    sample;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = REG_FREQ_MODE;
  cfg_data_t  cfg_data = '0;
  int         fails;
  int         pending;
  int         checked;

  bit tx_calm;
  int words_sent;
  int requests_sent;
  int settings_used;

  wavetable_oscillator_interp_core i_dut (.*);

  wavetable_oscillator_interp_checker i_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic freq_t rand_freq();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 4) return freq_t'($urandom_range(0, 4095));
    return freq_t'($urandom);
  endfunction

  function automatic sample_t rand_value();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return sample_t'(16'sh7fff);
    if (roll == 1) return sample_t'(16'sh8000);
    if (roll == 2) return '0;
    return sample_t'($urandom);
  endfunction

  // output side: random stalls, plus a long hold-off every so often
  initial begin : sample_sink
    int stall_left;
    int taken;
    int hold_at;
    bit rx_calm;
    stall_left = 0;
    taken      = 0;
    hold_at    = 150;
    rx_calm    = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if ($urandom_range(0, 127) == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (stall_left == 0) begin
        if (taken >= hold_at) begin
          stall_left = LONG_HOLD;
          hold_at    = hold_at + 700;
        end else begin
          stall_left = pick_gap(rx_calm);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(logic c, freq_t f, tindex_t idx, sample_t val);
    int gap;
    in_valid    <= 1'b1;
    cmd         <= c;
    freq_hz     <= f;
    table_index <= idx;
    table_value <= val;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (c == CMD_GENERATE) requests_sent++;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering words until every sample is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic mode, freq_t fixed, phase_t step);
    write_reg(REG_FREQ_MODE, cfg_data_t'(mode));
    write_reg(REG_FIXED_FREQ, cfg_data_t'(fixed));
    write_reg(REG_HZ_TO_PHASE, step);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic mode, freq_t fixed, phase_t step, int count);
    drain();
    set_regs(mode, fixed, step);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        send_word(CMD_WRITE, rand_freq(), tindex_t'($urandom), rand_value());
      else
        send_word(CMD_GENERATE, rand_freq(), tindex_t'($urandom), rand_value());
    end
  endtask

  initial begin : stimulus
    sample_t fill;
    tx_calm = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // whole table first, with full-scale neighbours so interpolation spans the range
    for (int i = 0; i < 512; i++) begin
      case (i % 4)
        0:       fill = sample_t'(16'sh7fff);
        1:       fill = sample_t'(16'sh8000);
        default: fill = rand_value();
      endcase
      send_word(CMD_WRITE, rand_freq(), tindex_t'(i), fill);
    end

    // step of 2^24 per hz makes the increment freq_hz << 8
    drain();
    set_regs(1'b1, FIXED_FREQ_RESET, 32'h0100_0000);
    send_word(CMD_GENERATE, 24'h000000, '0, '0);
    send_word(CMD_GENERATE, 24'hffffff, '1, '1);
    // now just below the wrap: last entry interpolates toward entry 0
    send_word(CMD_GENERATE, 24'h000000, '0, '0);
    send_word(CMD_WRITE, 24'h000000, tindex_t'(511), sample_t'(16'sh8000));
    send_word(CMD_WRITE, 24'hffffff, tindex_t'(0), sample_t'(16'sh7fff));
    send_word(CMD_GENERATE, 24'h000001, '0, '0);
    send_word(CMD_GENERATE, 24'h800000, '0, '0);
    send_word(CMD_GENERATE, 24'h7fffff, '0, '0);
    send_word(CMD_WRITE, 24'h000000, tindex_t'(511), sample_t'(16'sh7fff));
    send_word(CMD_WRITE, 24'h000000, tindex_t'(0), sample_t'(16'sh8000));
    send_word(CMD_GENERATE, 24'h000000, '0, '0);
    send_word(CMD_GENERATE, 24'h555555, '0, '0);
    drain();
    set_regs(1'b0, FIXED_FREQ_RESET, HZ_TO_PHASE_RESET);
    send_word(CMD_GENERATE, 24'hffffff, '0, '0);
    send_word(CMD_GENERATE, 24'h000000, '0, '0);
    send_word(CMD_GENERATE, 24'h123456, '0, '0);

    run_phase(1'b1, freq_t'($urandom), HZ_TO_PHASE_RESET, 200);
    run_phase(1'b1, freq_t'($urandom), 32'hffff_ffff, 200);
    run_phase(1'b0, 24'hffffff, 32'hffff_ffff, 200);
    run_phase(1'b0, 24'h000000, phase_t'($urandom), 200);
    run_phase(1'b1, freq_t'($urandom), 32'h0000_0000, 200);
    run_phase(1'b0, freq_t'($urandom), phase_t'($urandom), 200);
    run_phase(1'b1, freq_t'($urandom), phase_t'($urandom), 200);
    drain();

    $display("covered %0d words in, %0d sample requests, %0d samples compared",
             words_sent, requests_sent, checked);
    $display("%0d register settings incl. extremes, full table load, long output hold-offs",
             settings_used);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
